[hw/rtl/stwp_pkg.sv]
package stwp_pkg;

  // field widths
  localparam int COORD_W = 24;
  localparam int ANGLE_W = 16;
  localparam int TILT_W  = 16;
  localparam int OUT_W   = COORD_W + 2;
  localparam int DIST_W  = COORD_W + 1;
  localparam int GUARD   = 4;

  // CORDIC datapath
  localparam int CORDIC_STAGES = 16;
  localparam int CW = 34;  // x/y lanes, enough for gain growth on guarded coordinates
  localparam int ZW = 32;  // angle accumulator, binary turns

  localparam logic [ZW-1:0] ATAN_TAB [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // CORDIC gain removal, Q24
  localparam int GAIN_W = 24;
  localparam logic [GAIN_W-1:0] INV_GAIN = 24'd10188014;
  localparam int LO_W = 17;                  // low slice of the split product
  localparam int PH_W = CW - LO_W + GAIN_W + 1;
  localparam int PL_W = LO_W + GAIN_W;
  localparam int PW   = 60;                  // full product plus rounding

  // square root
  localparam int SQ_BITS = 26;
  localparam int SQ_N_W  = 2 * SQ_BITS;
  localparam int SQ_LAT  = SQ_BITS + 1;

  typedef enum logic [2:0] {
    CFG_TILT_COS = 3'd0,
    CFG_TILT_SIN = 3'd1,
    CFG_OFF_X    = 3'd2,
    CFG_OFF_Y    = 3'd3,
    CFG_OFF_Z    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [PH_W-1:0] hi;
    logic        [PL_W-1:0] lo;
  } pp_t;

  // first half of v * INV_GAIN: two narrow partial products
  function automatic pp_t comp_pp(input logic signed [CW-1:0] v);
    pp_t p;
    p.hi = $signed(v[CW-1:LO_W]) * $signed({1'b0, INV_GAIN});
    p.lo = v[LO_W-1:0] * INV_GAIN;
    return p;
  endfunction

  // second half: recombine, round half up, arithmetic shift by s
  function automatic logic signed [CW-1:0] comp_fin(input pp_t p, input logic [4:0] s);
    logic signed [PW-1:0] sum;
    logic signed [PW-1:0] res;
    sum = {{(PW-PH_W-LO_W){p.hi[PH_W-1]}}, p.hi, {LO_W{1'b0}}}
          + PW'(p.lo) + (PW'(1) << (s - 5'd1));
    res = sum >>> s;
    return res[CW-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [47:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 48'sd33554431) begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (v < -48'sd33554432) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ANGLE_W-1:0] from_turn32(input logic [ZW-1:0] z);
    logic [ZW-1:0] t;
    t = z + (ZW'(1) << (ZW - 1 - ANGLE_W));
    return t[ZW-1 -: ANGLE_W];
  endfunction

endpackage

[hw/rtl/sensor_to_world_point_transform.sv]
// Sensor-to-world point transform. Each item is one radar point, Cartesian (tuser 0) or
// range/azimuth/elevation (tuser 1); spherical points are turned Cartesian by two CORDIC
// rotations, then tilted about X, offset by the mount position and Z-negated to give the
// body frame, then rotated by heading plus stepper angle into the world frame. Distance,
// bearing and elevation follow from square-root and vectoring CORDIC units. The datapath
// is one flat pipeline: a new item is taken every clock unless the output stalls, and its
// result passes through the chain of four CORDIC units and the 27-stage horizontal square
// root in series. Output back-pressure freezes every stage at once, so items are held,
// never dropped. Config registers are plain writes and must only change while no item is
// in flight.
module sensor_to_world_point_transform import stwp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // in: coord_a, coord_b, coord_c, compass_heading, stepper_angle (low bit up)
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [103:0]       s_axis_tdata,
  input  logic               s_axis_tuser,   // cmd
  // out: body_x, body_y, body_z, world_x, world_y, world_z, distance, bearing,
  //      elevation, zero pad (low bit up)
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [215:0]       m_axis_tdata,
  // config writes
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [COORD_W-1:0] cfg_data_i
);

  // stage numbers, counted from the input register
  localparam int P_C1 = CORDIC_STAGES;        // elevation rotation out
  localparam int P_M1 = P_C1 + 2;             // gain removed
  localparam int P_C2 = P_M1 + CORDIC_STAGES; // azimuth rotation out
  localparam int P_M2 = P_C2 + 2;
  localparam int P_TM = P_M2 + 1;             // select + tilt products
  localparam int P_TS = P_TM + 1;             // tilt sums
  localparam int P_BD = P_TS + 1;             // body frame
  localparam int P_W  = P_BD + CORDIC_STAGES; // world rotation out
  localparam int P_WM = P_W + 2;
  localparam int P_WS = P_WM + 1;             // world saturated
  localparam int P_DN = P_BD + 2;             // distance sum of squares
  localparam int P_DR = P_DN + SQ_LAT;
  localparam int P_DS = P_DR + 1;
  localparam int P_HN = P_WS + 2;             // horizontal sum of squares
  localparam int P_HR = P_HN + SQ_LAT;
  localparam int P_BR = P_WS + CORDIC_STAGES; // bearing vectoring out
  localparam int P_BA = P_BR + 1;
  localparam int P_EL = P_HR + CORDIC_STAGES; // elevation vectoring out
  localparam int P_OUT = P_EL + 1;

  localparam logic [DIST_W-1:0] DMAX = '1;
  localparam logic signed [ANGLE_W-1:0] QUARTER = ANGLE_W'(1) << (ANGLE_W - 2);

  typedef struct packed {
    logic                      cmd;
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] c;
    logic        [ANGLE_W-1:0] hdg;
    logic signed [OUT_W-1:0]   zs;
  } sb_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] bx;
    logic signed [OUT_W-1:0] by;
    logic signed [OUT_W-1:0] bz;
    logic signed [OUT_W-1:0] wx;
    logic signed [OUT_W-1:0] wy;
    logic        [DIST_W-1:0] dist_len;
    logic        [ANGLE_W-1:0] bear;
  } res_t;

  function automatic logic [OUT_W-1:0] abs_out(input logic signed [OUT_W-1:0] v);
    return v[OUT_W-1] ? (~v + 1'b1) : v;
  endfunction

  // ---------------------------------------------------------------- config
  logic signed [TILT_W-1:0]  tilt_cos_q, tilt_sin_q;
  logic signed [COORD_W-1:0] off_x_q, off_y_q, off_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_cos_q <= 16'sd32767;
      tilt_sin_q <= '0;
      off_x_q    <= '0;
      off_y_q    <= '0;
      off_z_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TILT_COS: tilt_cos_q <= cfg_data_i[TILT_W-1:0];
        CFG_TILT_SIN: tilt_sin_q <= cfg_data_i[TILT_W-1:0];
        CFG_OFF_X:    off_x_q    <= cfg_data_i;
        CFG_OFF_Y:    off_y_q    <= cfg_data_i;
        CFG_OFF_Z:    off_z_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // single enable for the whole pipe; the last stage is the output register
  logic en;
  logic [P_OUT:0] vld_q;

  assign en            = ~vld_q[P_OUT] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[P_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[P_OUT-1:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------- datapath
  sb_t  sb_q  [0:P_M2];
  res_t res_q [P_BD:P_OUT];
  res_t res_d [P_BD+1:P_OUT];
  sb_t  sb_in;
  sb_t  sb_m1_d;
  res_t body_d;

  logic signed [CW-1:0] c1_x, c1_xo, c1_yo, c2_xo, c2_yo, w_xo, w_yo;
  logic        [ZW-1:0] c1_z, c2_z, w_z, br_zo, el_zo;
  pp_t  c1pp_x_q, c1pp_y_q, c2pp_x_q, c2pp_y_q, wpp_x_q, wpp_y_q;
  logic signed [CW-1:0] hg_q, wxr_q, wyr_q;
  logic signed [CW-1:0] zs_full, ys_full, xs_full;
  logic signed [OUT_W-1:0] xs_q, ys_q;

  // tilt
  logic signed [OUT_W-1:0] xm, ym, zm;
  logic signed [OUT_W-1:0] tx_q, tx2_q;
  logic signed [TILT_W+OUT_W-1:0] tcy_q, tsz_q, tsy_q, tcz_q;
  logic signed [TILT_W+OUT_W+1:0] ry_s, rz_s;
  logic signed [27:0] ry_q, rz_q;
  logic [ANGLE_W-1:0] hdg_tm_q, hdg_ts_q, hdg_bd_q;

  // norms
  logic [SQ_N_W-1:0]  dsq_q [3];
  logic [SQ_N_W-1:0]  dsum_q;
  logic [SQ_BITS-1:0] droot;
  logic [SQ_N_W-1:0]  hsq_q [2];
  logic [SQ_N_W-1:0]  hsum_q;
  logic [SQ_BITS-1:0] hroot;

  logic signed [ANGLE_W-1:0] el_raw;
  logic signed [ANGLE_W-1:0] el_q;

  always_comb begin
    sb_in.cmd = s_axis_tuser;
    sb_in.a   = s_axis_tdata[23:0];
    sb_in.b   = s_axis_tdata[47:24];
    sb_in.c   = s_axis_tdata[71:48];
    sb_in.hdg = s_axis_tdata[87:72] + s_axis_tdata[103:88];  // wraps mod one turn
    sb_in.zs  = '0;

    // negative range counts as zero
    c1_x = sb_q[0].a[COORD_W-1] ? '0 : (CW'(sb_q[0].a) <<< GUARD);
    c1_z = {sb_q[0].c[ANGLE_W-1:0], {(ZW-ANGLE_W){1'b0}}};
    c2_z = {sb_q[P_M1].b[ANGLE_W-1:0], {(ZW-ANGLE_W){1'b0}}};

    // spherical z joins the sideband once its gain is removed
    zs_full    = comp_fin(c1pp_y_q, 5'(24 + GUARD));
    sb_m1_d    = sb_q[P_M1-1];
    sb_m1_d.zs = zs_full[OUT_W-1:0];
    ys_full    = comp_fin(c2pp_x_q, 5'(24 + GUARD));
    xs_full    = comp_fin(c2pp_y_q, 5'(24 + GUARD));

    xm = sb_q[P_M2].cmd ? xs_q         : OUT_W'(sb_q[P_M2].a);
    ym = sb_q[P_M2].cmd ? ys_q         : OUT_W'(sb_q[P_M2].b);
    zm = sb_q[P_M2].cmd ? sb_q[P_M2].zs : OUT_W'(sb_q[P_M2].c);

    ry_s = (TILT_W+OUT_W+2)'(tcy_q) - (TILT_W+OUT_W+2)'(tsz_q) + 16384;
    rz_s = (TILT_W+OUT_W+2)'(tsy_q) + (TILT_W+OUT_W+2)'(tcz_q) + 16384;

    body_d    = '0;
    body_d.bx = sat_out(48'(tx2_q) + 48'(off_x_q));
    body_d.by = sat_out(48'(ry_q)  + 48'(off_y_q));
    body_d.bz = sat_out(48'(off_z_q) - 48'(rz_q));

    w_z = ZW'(0) - {hdg_bd_q, {(ZW-ANGLE_W){1'b0}}};

    // result record moves on, fields filled in as they become ready
    for (int k = P_BD + 1; k <= P_OUT; k++) res_d[k] = res_q[k-1];
    res_d[P_WS].wx = sat_out(48'(wxr_q));
    res_d[P_WS].wy = sat_out(48'(wyr_q));
    res_d[P_DS].dist_len = (droot > SQ_BITS'(DMAX)) ? DMAX : droot[DIST_W-1:0];
    res_d[P_BA].bear = from_turn32(br_zo);

    el_raw = from_turn32(el_zo);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sb_in;
      for (int k = 1; k <= P_M2; k++) sb_q[k] <= (k == P_M1) ? sb_m1_d : sb_q[k-1];

      // spherical: gain removal after each rotation
      c1pp_x_q <= comp_pp(c1_xo);
      c1pp_y_q <= comp_pp(c1_yo);
      hg_q     <= comp_fin(c1pp_x_q, 5'd24);
      c2pp_x_q <= comp_pp(c2_xo);
      c2pp_y_q <= comp_pp(c2_yo);
      ys_q     <= ys_full[OUT_W-1:0];
      xs_q     <= xs_full[OUT_W-1:0];

      // tilt about X
      tx_q     <= xm;
      tcy_q    <= tilt_cos_q * ym;
      tsz_q    <= tilt_sin_q * zm;
      tsy_q    <= tilt_sin_q * ym;
      tcz_q    <= tilt_cos_q * zm;
      hdg_tm_q <= sb_q[P_M2].hdg;
      tx2_q    <= tx_q;
      ry_q     <= 28'(ry_s >>> 15);
      rz_q     <= 28'(rz_s >>> 15);
      hdg_ts_q <= hdg_tm_q;
      hdg_bd_q <= hdg_ts_q;

      for (int k = P_BD + 1; k <= P_OUT; k++) res_q[k] <= res_d[k];
      res_q[P_BD] <= body_d;

      wpp_x_q <= comp_pp(w_xo);
      wpp_y_q <= comp_pp(w_yo);
      wxr_q   <= comp_fin(wpp_x_q, 5'(24 + GUARD));
      wyr_q   <= comp_fin(wpp_y_q, 5'(24 + GUARD));

      // body distance
      dsq_q[0] <= abs_out(res_q[P_BD].bx) * abs_out(res_q[P_BD].bx);
      dsq_q[1] <= abs_out(res_q[P_BD].by) * abs_out(res_q[P_BD].by);
      dsq_q[2] <= abs_out(res_q[P_BD].bz) * abs_out(res_q[P_BD].bz);
      dsum_q   <= dsq_q[0] + dsq_q[1] + dsq_q[2];

      // horizontal length in the world frame
      hsq_q[0] <= abs_out(res_q[P_WS].wx) * abs_out(res_q[P_WS].wx);
      hsq_q[1] <= abs_out(res_q[P_WS].wy) * abs_out(res_q[P_WS].wy);
      hsum_q   <= hsq_q[0] + hsq_q[1];

      // elevation held to a quarter turn either way
      if (el_raw > QUARTER) begin
        el_q <= QUARTER;
      end else if (el_raw < -QUARTER) begin
        el_q <= -QUARTER;
      end else begin
        el_q <= el_raw;
      end
    end
  end

  stwp_cordic u_rot_el (
    .clk_i (clk_i),
    .en_i  (en),
    .vec_i (1'b0),
    .x_i   (c1_x),
    .y_i   ('0),
    .z_i   (c1_z),
    .x_o   (c1_xo),
    .y_o   (c1_yo),
    .z_o   ()
  );

  stwp_cordic u_rot_az (
    .clk_i (clk_i),
    .en_i  (en),
    .vec_i (1'b0),
    .x_i   (hg_q),
    .y_i   ('0),
    .z_i   (c2_z),
    .x_o   (c2_xo),
    .y_o   (c2_yo),
    .z_o   ()
  );

  stwp_cordic u_rot_world (
    .clk_i (clk_i),
    .en_i  (en),
    .vec_i (1'b0),
    .x_i   (CW'(res_q[P_BD].bx) <<< GUARD),
    .y_i   (CW'(res_q[P_BD].by) <<< GUARD),
    .z_i   (w_z),
    .x_o   (w_xo),
    .y_o   (w_yo),
    .z_o   ()
  );

  stwp_isqrt u_sqrt_dist (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (dsum_q),
    .r_o   (droot)
  );

  stwp_isqrt u_sqrt_horiz (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (hsum_q),
    .r_o   (hroot)
  );

  // bearing: angle of (north, east)
  stwp_cordic u_vec_bear (
    .clk_i (clk_i),
    .en_i  (en),
    .vec_i (1'b1),
    .x_i   (CW'(res_q[P_WS].wy) <<< GUARD),
    .y_i   (CW'(res_q[P_WS].wx) <<< GUARD),
    .z_i   ('0),
    .x_o   (),
    .y_o   (),
    .z_o   (br_zo)
  );

  // elevation: angle of (horizontal, up)
  stwp_cordic u_vec_elev (
    .clk_i (clk_i),
    .en_i  (en),
    .vec_i (1'b1),
    .x_i   (CW'({hroot, {GUARD{1'b0}}})),
    .y_i   (CW'(res_q[P_HR].bz) <<< GUARD),
    .z_i   ('0),
    .x_o   (),
    .y_o   (),
    .z_o   (el_zo)
  );

  assign m_axis_tdata = {3'b000, el_q, res_q[P_OUT].bear, res_q[P_OUT].dist_len,
                         res_q[P_OUT].bz, res_q[P_OUT].wy, res_q[P_OUT].wx,
                         res_q[P_OUT].bz, res_q[P_OUT].by, res_q[P_OUT].bx};

endmodule

[hw/rtl/stwp_cordic.sv]
module stwp_cordic import stwp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic                 vec_i,   // 1 vectoring, 0 rotation
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic        [ZW-1:0] z_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic        [ZW-1:0] z_o
);

  logic signed [CW-1:0] x_in [CORDIC_STAGES];
  logic signed [CW-1:0] y_in [CORDIC_STAGES];
  logic        [ZW-1:0] z_in [CORDIC_STAGES];
  logic signed [CW-1:0] x_d  [CORDIC_STAGES];
  logic signed [CW-1:0] y_d  [CORDIC_STAGES];
  logic        [ZW-1:0] z_d  [CORDIC_STAGES];
  logic signed [CW-1:0] x_q  [CORDIC_STAGES];
  logic signed [CW-1:0] y_q  [CORDIC_STAGES];
  logic        [ZW-1:0] z_q  [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] up;
  logic [CORDIC_STAGES-1:0] zero_q;
  logic flip;
  logic zero_d;

  always_comb begin
    // fold into the right half plane first
    flip   = vec_i ? x_i[CW-1] : (z_i[ZW-1] ^ z_i[ZW-2]);
    zero_d = vec_i & (x_i == '0) & (y_i == '0);
    x_in[0] = flip ? -x_i : x_i;
    y_in[0] = flip ? -y_i : y_i;
    z_in[0] = flip ? z_i + {1'b1, {(ZW-1){1'b0}}} : z_i;
    for (int j = 1; j < CORDIC_STAGES; j++) begin
      x_in[j] = x_q[j-1];
      y_in[j] = y_q[j-1];
      z_in[j] = z_q[j-1];
    end
    for (int j = 0; j < CORDIC_STAGES; j++) begin
      up[j] = vec_i ? ~y_in[j][CW-1] : z_in[j][ZW-1];
      if (up[j]) begin
        x_d[j] = x_in[j] + (y_in[j] >>> j);
        y_d[j] = y_in[j] - (x_in[j] >>> j);
        z_d[j] = z_in[j] + ATAN_TAB[j];
      end else begin
        x_d[j] = x_in[j] - (y_in[j] >>> j);
        y_d[j] = y_in[j] + (x_in[j] >>> j);
        z_d[j] = z_in[j] - ATAN_TAB[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < CORDIC_STAGES; j++) begin
        x_q[j] <= x_d[j];
        y_q[j] <= y_d[j];
        z_q[j] <= z_d[j];
      end
      zero_q <= {zero_q[CORDIC_STAGES-2:0], zero_d};
    end
  end

  assign x_o = x_q[CORDIC_STAGES-1];
  assign y_o = y_q[CORDIC_STAGES-1];
  // null vector has angle zero
  assign z_o = zero_q[CORDIC_STAGES-1] ? '0 : z_q[CORDIC_STAGES-1];

endmodule

[hw/rtl/stwp_isqrt.sv]
module stwp_isqrt import stwp_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SQ_N_W-1:0]  n_i,
  output logic [SQ_BITS-1:0] r_o
);

  // one root bit per stage, then round to nearest
  logic [SQ_N_W-1:0]  m_in [SQ_BITS];
  logic [SQ_BITS-1:0] r_in [SQ_BITS];
  logic [SQ_N_W-1:0]  m_d  [SQ_BITS];
  logic [SQ_BITS-1:0] r_d  [SQ_BITS];
  logic [SQ_N_W-1:0]  m_q  [SQ_BITS];
  logic [SQ_BITS-1:0] r_q  [SQ_BITS];
  logic [SQ_N_W:0]    t    [SQ_BITS];
  logic [SQ_BITS-1:0] rnd_d;
  logic [SQ_BITS-1:0] rnd_q;

  always_comb begin
    m_in[0] = n_i;
    r_in[0] = '0;
    for (int j = 1; j < SQ_BITS; j++) begin
      m_in[j] = m_q[j-1];
      r_in[j] = r_q[j-1];
    end
    for (int j = 0; j < SQ_BITS; j++) begin
      t[j] = ((SQ_N_W+1)'(r_in[j]) << (SQ_BITS - j))
             + ((SQ_N_W+1)'(1) << (2 * (SQ_BITS - 1 - j)));
      if ({1'b0, m_in[j]} >= t[j]) begin
        m_d[j] = m_in[j] - t[j][SQ_N_W-1:0];
        r_d[j] = r_in[j] | (SQ_BITS'(1) << (SQ_BITS - 1 - j));
      end else begin
        m_d[j] = m_in[j];
        r_d[j] = r_in[j];
      end
    end
    // remainder above root: nearer to root + 1
    rnd_d = (m_q[SQ_BITS-1] > SQ_N_W'(r_q[SQ_BITS-1])) ? r_q[SQ_BITS-1] + 1'b1
                                                        : r_q[SQ_BITS-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < SQ_BITS; j++) begin
        m_q[j] <= m_d[j];
        r_q[j] <= r_d[j];
      end
      rnd_q <= rnd_d;
    end
  end

  assign r_o = rnd_q;

endmodule

[dv/sensor_to_world_point_transform_checker.sv]
`timescale 1ns / 1ps

module sensor_to_world_point_transform_checker import stwp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [103:0]       s_axis_tdata,
  input  logic               s_axis_tuser,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [215:0]       m_axis_tdata,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [COORD_W-1:0] cfg_data_i,
  output int                 fail_count_o,
  output int                 points_pending_o
);

  typedef struct packed {
    logic signed [OUT_W-1:0]   bx, by, bz, wx, wy, wz;
    logic        [DIST_W-1:0]  dist_len;
    logic        [ANGLE_W-1:0] bearing;
    logic signed [ANGLE_W-1:0] elev;
  } point_res_t;

  localparam longint GAIN_Q24 = 64'd10188014;

  longint tilt_c, tilt_s, off_x, off_y, off_z;
  point_res_t expected_points[$];

  assign points_pending_o = expected_points.size();

  function automatic longint gain_fix(longint v, int s);
    return (v * GAIN_Q24 + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip_out(longint v);
    if (v > 64'sd33554431) return 64'sd33554431;
    if (v < -64'sd33554432) return -64'sd33554432;
    return v;
  endfunction

  function automatic void cordic_rot(inout longint x, inout longint y, input bit [31:0] a);
    longint dx, dy;
    if (a[31:30] == 2'd1 || a[31:30] == 2'd2) begin
      x = -x; y = -y; a = a + 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (a[31]) begin
        x += dx; y -= dy; a = a + ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; a = a - ATAN_TAB[i];
      end
    end
  endfunction

  function automatic bit [31:0] cordic_vec(longint x, longint y);
    bit [31:0] z;
    longint dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z = z + ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z = z - ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned root_rnd(longint unsigned n);
    longint unsigned r, b, m;
    r = 0; b = 64'd1 << 62; m = n;
    while (b > m) b >>= 2;
    while (b != 0) begin
      if (m >= r + b) begin
        m -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (n - r * r > r) r++;
    return r;
  endfunction

  function automatic longint unsigned vec_len(longint a, longint b, longint c);
    longint unsigned ua, ub, uc;
    int k;
    ua = a < 0 ? -a : a; ub = b < 0 ? -b : b; uc = c < 0 ? -c : c;
    k = 0;
    while ((ua | ub | uc) >= (64'd1 << 31)) begin
      ua >>= 1; ub >>= 1; uc >>= 1; k++;
    end
    return root_rnd(ua * ua + ub * ub + uc * uc) << k;
  endfunction

  function automatic bit [15:0] turn_round(bit [31:0] z);
    bit [31:0] t;
    t = z + 32'h8000;
    return t[31:16];
  endfunction

  function automatic point_res_t transform_point(logic sph, logic [103:0] d);
    point_res_t p;
    longint x, y, z, ry, rz, bx, by, bz, wx, wy, cx, cy, hg, r, el;
    longint unsigned len, horiz;
    bit [15:0] hsum;
    if (sph) begin
      r = longint'($signed(d[23:0]));
      if (r < 0) r = 0;
      cx = r * 16; cy = 0;
      // angles use the low 16 bits of coord_c and coord_b
      cordic_rot(cx, cy, {d[63:48], 16'h0});
      hg = gain_fix(cx, 24);
      z = gain_fix(cy, 28);
      cx = hg; cy = 0;
      cordic_rot(cx, cy, {d[39:24], 16'h0});
      y = gain_fix(cx, 28);
      x = gain_fix(cy, 28);
    end else begin
      x = longint'($signed(d[23:0]));
      y = longint'($signed(d[47:24]));
      z = longint'($signed(d[71:48]));
    end
    ry = (tilt_c * y - tilt_s * z + 16384) >>> 15;
    rz = (tilt_s * y + tilt_c * z + 16384) >>> 15;
    bx = clip_out(x + off_x);
    by = clip_out(ry + off_y);
    bz = clip_out(off_z - rz);
    hsum = d[87:72] + d[103:88];
    cx = bx * 16; cy = by * 16;
    cordic_rot(cx, cy, 32'd0 - {hsum, 16'h0});
    wx = clip_out(gain_fix(cx, 28));
    wy = clip_out(gain_fix(cy, 28));
    len = vec_len(bx, by, bz);
    if (len > 64'd33554431) len = 64'd33554431;
    horiz = vec_len(wx, wy, 0);
    el = longint'($signed(turn_round(cordic_vec(longint'(horiz) * 16, bz * 16))));
    if (el > 16384) el = 16384;
    if (el < -16384) el = -16384;
    p.bx = OUT_W'(bx); p.by = OUT_W'(by); p.bz = OUT_W'(bz);
    p.wx = OUT_W'(wx); p.wy = OUT_W'(wy); p.wz = OUT_W'(bz);
    p.dist_len = DIST_W'(len);
    p.bearing = turn_round(cordic_vec(wy * 16, wx * 16));
    p.elev = ANGLE_W'(el);
    return p;
  endfunction

  // register mirror, updated on the same edge as the block
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_c = 32767; tilt_s = 0; off_x = 0; off_y = 0; off_z = 0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TILT_COS: tilt_c = longint'($signed(cfg_data_i[15:0]));
        CFG_TILT_SIN: tilt_s = longint'($signed(cfg_data_i[15:0]));
        CFG_OFF_X:    off_x  = longint'($signed(cfg_data_i));
        CFG_OFF_Y:    off_y  = longint'($signed(cfg_data_i));
        CFG_OFF_Z:    off_z  = longint'($signed(cfg_data_i));
        default: ;
      endcase
    end
  end

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    point_res_t exp_p, got_p;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_points.push_back(transform_point(s_axis_tuser, s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_p.bx = m_axis_tdata[25:0];     got_p.by = m_axis_tdata[51:26];
      got_p.bz = m_axis_tdata[77:52];    got_p.wx = m_axis_tdata[103:78];
      got_p.wy = m_axis_tdata[129:104];  got_p.wz = m_axis_tdata[155:130];
      got_p.dist_len = m_axis_tdata[180:156];
      got_p.bearing = m_axis_tdata[196:181];
      got_p.elev = m_axis_tdata[212:197];
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected item, none pending: %h", $time, got_p);
        fail_count_o++;
      end else begin
        exp_p = expected_points.pop_front();
        if (exp_p !== got_p) begin
          $display("%0t: mismatch", $time);
          $display("  exp bx %0d by %0d bz %0d wx %0d wy %0d wz %0d d %0d brg %0d el %0d",
                   exp_p.bx, exp_p.by, exp_p.bz, exp_p.wx, exp_p.wy, exp_p.wz,
                   exp_p.dist_len, exp_p.bearing, exp_p.elev);
          $display("  got bx %0d by %0d bz %0d wx %0d wy %0d wz %0d d %0d brg %0d el %0d",
                   got_p.bx, got_p.by, got_p.bz, got_p.wx, got_p.wy, got_p.wz,
                   got_p.dist_len, got_p.bearing, got_p.elev);
          fail_count_o++;
        end
      end
    end
  end

endmodule

[dv/sensor_to_world_point_transform_test.sv]
`timescale 1ns / 1ps

module sensor_to_world_point_transform_test;
  import stwp_pkg::*;

  // pipeline depth of the block with 16 CORDIC stages, plus margin
  localparam int DRAIN_CYCLES = 140;
  localparam int CYCLE_LIMIT  = 2000000;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [103:0]       s_axis_tdata;   // coord_a, coord_b, coord_c, heading, stepper
  logic               s_axis_tuser;   // cmd: 0 Cartesian, 1 spherical
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [215:0]       m_axis_tdata;   // body xyz, world xyz, distance, bearing, elevation
  logic               cfg_we_i;
  cfg_idx_e           cfg_idx;
  logic [COORD_W-1:0] cfg_data_i;

  int fail_count;
  int points_pending;
  int send_idle_pct;   // chance in 100 that the sender holds off an item
  int recv_stall_pct;  // chance in 100 that the receiver drops ready
  int cycle_count;

  sensor_to_world_point_transform dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i(cfg_idx), .cfg_data_i
  );

  sensor_to_world_point_transform_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i(cfg_idx), .cfg_data_i,
    .fail_count_o(fail_count), .points_pending_o(points_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls as the current idling mode asks
  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one item onto the input stream; valid stays high across back-to-back items
  task automatic send_point(logic sph, logic [23:0] a, logic [23:0] b, logic [23:0] c,
                            logic [15:0] hdg, logic [15:0] stp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= sph;
    s_axis_tdata  <= {stp, hdg, c, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // block must be empty before registers change
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (points_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx    <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_mount(logic [15:0] cs, logic [15:0] sn,
                           logic [23:0] ox, logic [23:0] oy, logic [23:0] oz);
    write_reg(CFG_TILT_COS, {8'h0, cs});
    write_reg(CFG_TILT_SIN, {8'h0, sn});
    write_reg(CFG_OFF_X, ox);
    write_reg(CFG_OFF_Y, oy);
    write_reg(CFG_OFF_Z, oz);
    cfg_we_i <= 1'b0;
  endtask

  // coordinates: full range half the time, else small values or the extremes
  function automatic logic [23:0] pick_coord();
    case ($urandom_range(3))
      0: return 24'($signed($urandom_range(8000)) - 4000);
      1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic directed_points();
    send_point(0, 0, 0, 0, 0, 0);                         // zero vector
    send_point(0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF);
    send_point(0, 24'h800000, 24'h800000, 24'h800000, 16'h8000, 16'h8000);
    send_point(0, 24'h7FFFFF, 24'h800000, 24'h000001, 16'h4000, 16'hC000);
    send_point(0, 0, 0, 24'h001000, 0, 0);                // straight along z
    send_point(0, 24'h000100, 0, 0, 16'h0001, 16'hFFFF);  // heading sum wraps to zero
    send_point(1, 24'h7FFFFF, 0, 0, 0, 0);                // max range, zero angles
    send_point(1, 24'h800000, 24'h004000, 24'h002000, 0, 0); // negative range
    send_point(1, 24'hFFFFFF, 24'h001234, 24'h000321, 0, 0);
    send_point(1, 24'h100000, 24'h004000, 0, 16'h1000, 0);
    send_point(1, 24'h100000, 24'h008000, 0, 0, 16'h2000);
    send_point(1, 24'h100000, 24'h00C000, 24'h004000, 0, 0); // elevation straight up
    send_point(1, 24'h100000, 24'h000000, 24'h00C000, 0, 0); // straight down
    send_point(1, 24'h100000, 24'hFF2000, 24'hAB1000, 0, 0); // angle high bits ignored
    send_point(1, 24'h7FFFFF, 24'h00FFFF, 24'h00FFFF, 16'hFFFF, 16'h0001);
    send_point(1, 24'h000001, 24'h006000, 24'h00A000, 16'h7FFF, 16'h8001);
    send_point(0, 24'hFFFFFF, 24'h000001, 24'hFFFFFF, 16'h5555, 16'hAAAA);
  endtask

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) begin
      send_point(1'($urandom_range(1)), pick_coord(), pick_coord(), pick_coord(),
                 16'($urandom()), 16'($urandom()));
    end
  endtask

  initial begin
    s_axis_tvalid  = 1'b0;
    s_axis_tuser   = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx        = CFG_TILT_COS;
    cfg_data_i     = '0;
    cycle_count    = 0;
    send_idle_pct  = 32;
    recv_stall_pct = 49;
    rst_ni         = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: level mount, no offset
    directed_points();
    random_points(60);
    drain_pipe();

    // extreme tilt and largest offsets, overflow into saturation
    set_mount(16'h8000, 16'h7FFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    directed_points();
    random_points(60);
    drain_pipe();

    // idling the other way round
    send_idle_pct  = 49;
    recv_stall_pct = 32;
    set_mount(16'h7FFF, 16'h8000, 24'h800000, 24'h800000, 24'h800000);
    random_points(80);
    drain_pipe();

    // a realistic tilt of about 30 degrees and a small offset
    set_mount(16'h6EDA, 16'h4000, 24'h000640, 24'hFFF9C0, 24'h001900);
    random_points(80);
    drain_pipe();

    // no idling either side
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_mount(16'($urandom()), 16'($urandom()), 24'($urandom()), 24'($urandom()),
              24'($urandom()));
    random_points(100);
    drain_pipe();

    set_mount(16'h0000, 16'h0000, 24'h000000, 24'h000000, 24'h000000);
    directed_points();
    random_points(60);
    drain_pipe();

    if (fail_count == 0 && points_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
